// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the CRC codeword byte encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- design/ccbe_pkg.sv -----
// Shared constants and types of the CRC codeword byte encoder.
`default_nettype none

package ccbe_pkg;

	localparam int DEF_MAX_GEN_LEN = 17;
	localparam int BYTE_BITS       = 8;
	localparam int CFG_GEN_W       = 17;
	localparam int GEN_LEN_W       = 5;
	localparam int CFG_DATA_W      = 17;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_GEN_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_GEN_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 2'd2;

	localparam logic [CFG_GEN_W-1:0] RST_GEN_BITS = 17'd11;
	localparam logic [GEN_LEN_W-1:0] RST_GEN_LEN  = 5'd4;
	localparam logic                 RST_MODE     = 1'b1;

	localparam logic [7:0] ASCII_ZERO = 8'd48;

	// classification of one queued item
	typedef struct packed {
		logic       hdr;   // header byte goes out before this item
		logic       mode;  // 1: whole byte, 0: two nibbles
		logic [2:0] pad;   // leading zero bits
	} ent_ctrl_t;

endpackage

`default_nettype wire

// ----- design/ccbe_front.sv -----
// Front end: accepts bytes, computes CRC remainders and classifies each item.
`default_nettype none

module ccbe_front #(
	parameter int MAX_GEN_LEN = ccbe_pkg::DEF_MAX_GEN_LEN
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire logic [7:0]                      data_byte,
	input  wire logic [ccbe_pkg::CFG_GEN_W-1:0]  generator_bits,
	input  wire logic [ccbe_pkg::GEN_LEN_W-1:0]  gen_len,
	input  wire logic                            dataword_mode,
	output ccbe_pkg::ent_ctrl_t                  ctrl,
	output logic [$clog2(MAX_GEN_LEN)-1:0]       rbits,
	output logic [$clog2(((2*(MAX_GEN_LEN+3))+7)/8)-1:0] last_idx,
	output logic [MAX_GEN_LEN-2:0]               rem_a,
	output logic [MAX_GEN_LEN-2:0]               rem_b
);

	localparam int R    = MAX_GEN_LEN - 1;
	localparam int RBW  = $clog2(MAX_GEN_LEN);
	localparam int NB   = ((2 * (MAX_GEN_LEN + 3)) + 7) / ccbe_pkg::BYTE_BITS;
	localparam int IDXW = $clog2(NB);
	localparam int TW   = $clog2(NB * ccbe_pkg::BYTE_BITS + 8);

	logic            first_pending_q;
	logic [4:0]      len_m1;
	logic [R-1:0]    gen_r;
	logic [R-1:0]    low_mask;
	logic [R-1:0]    poly_al;
	logic [RBW-1:0]  shamt;
	logic [R-1:0]    ra, rb;
	logic            fb_a, fb_b;
	logic [TW-1:0]   total;
	logic [TW-1:0]   nbytes;

	for (genvar gi = 0; gi < R; gi++) begin : g_gen
		if (gi < ccbe_pkg::CFG_GEN_W) begin : g_bit
			assign gen_r[gi] = generator_bits[gi];
		end else begin : g_zero
			assign gen_r[gi] = 1'b0;
		end
	end

	// clamp the generator length, remainder width is length minus one
	always_comb begin
		len_m1 = gen_len - 5'd1;
		if (gen_len < 5'd2) begin
			rbits = RBW'(1);
		end else if (32'(gen_len) > 32'(MAX_GEN_LEN)) begin
			rbits = RBW'(R);
		end else begin
			rbits = RBW'(len_m1);
		end
	end

	// remainder kept left-aligned so the shift-in position is fixed;
	// the generator's top bit never reaches the remainder
	always_comb begin
		for (int i = 0; i < R; i++) begin
			low_mask[i] = (RBW'(i) < rbits);
		end
		shamt   = RBW'(R) - rbits;
		poly_al = (gen_r & low_mask) << shamt;
	end

	always_comb begin
		ra   = '0;
		rb   = '0;
		fb_a = 1'b0;
		fb_b = 1'b0;
		if (dataword_mode) begin
			for (int k = 7; k >= 0; k--) begin
				fb_a = data_byte[k] ^ ra[R-1];
				ra   = (ra << 1) ^ ({R{fb_a}} & poly_al);
			end
		end else begin
			for (int k = 3; k >= 0; k--) begin
				fb_a = data_byte[k+4] ^ ra[R-1];
				fb_b = data_byte[k] ^ rb[R-1];
				ra   = (ra << 1) ^ ({R{fb_a}} & poly_al);
				rb   = (rb << 1) ^ ({R{fb_b}} & poly_al);
			end
		end
		rem_a = ra >> shamt;
		rem_b = rb >> shamt;
	end

	always_comb begin
		if (dataword_mode) begin
			total = TW'(8) + TW'(rbits);
		end else begin
			total = TW'(8) + (TW'(rbits) << 1);
		end
		nbytes        = (total + TW'(7)) >> 3;
		last_idx      = IDXW'(nbytes - TW'(1));
		ctrl.hdr      = first_pending_q;
		ctrl.mode     = dataword_mode;
		ctrl.pad      = 3'd0 - total[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q <= 1'b1;
		end else if (accept) begin
			first_pending_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- design/ccbe_fifo.sv -----
// Two-entry queue between the front end and the byte serializer.
`default_nettype none

module ccbe_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  not_empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/ccbe_back.sv -----
// Back end: builds the codeword word of one item and sends it out byte by byte.
`default_nettype none

module ccbe_back #(
	parameter int MAX_GEN_LEN = ccbe_pkg::DEF_MAX_GEN_LEN
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  q_not_empty,
	input  ccbe_pkg::ent_ctrl_t                        q_ctrl,
	input  wire logic [$clog2(MAX_GEN_LEN)-1:0]        q_rbits,
	input  wire logic [$clog2(((2*(MAX_GEN_LEN+3))+7)/8)-1:0] q_last_idx,
	input  wire logic [7:0]                            q_data,
	input  wire logic [MAX_GEN_LEN-2:0]                q_rem_a,
	input  wire logic [MAX_GEN_LEN-2:0]                q_rem_b,
	output logic                                       q_pop,
	input  wire logic                                  pop,
	output logic                                       empty,
	output logic [7:0]                                 out_byte,
	output logic                                       is_header,
	output logic                                       last
);

	localparam int RBW  = $clog2(MAX_GEN_LEN);
	localparam int NB   = ((2 * (MAX_GEN_LEN + 3)) + 7) / ccbe_pkg::BYTE_BITS;
	localparam int IDXW = $clog2(NB);
	localparam int VW   = NB * ccbe_pkg::BYTE_BITS;

	logic            busy_q;
	logic            hdr_q;
	logic [IDXW-1:0] idx_q;
	logic [VW-1:0]   word_q;
	logic [7:0]      hbyte_q;

	logic            at_end;
	logic            load;
	logic [RBW+2:0]  cw_len;
	logic [VW-1:0]   cw_hi, cw_lo, word_d;

	assign at_end = pop && !hdr_q && (idx_q == '0);
	assign load   = q_not_empty && (!busy_q || at_end);
	assign q_pop  = load;

	// codeword words are right-aligned: the pad zeros are the unused top bits
	always_comb begin
		cw_len = (RBW+3)'(q_rbits) + (RBW+3)'(4);
		if (q_ctrl.mode) begin
			cw_hi  = '0;
			cw_lo  = '0;
			word_d = (VW'(q_data) << q_rbits) | VW'(q_rem_a);
		end else begin
			cw_hi  = (VW'(q_data[7:4]) << q_rbits) | VW'(q_rem_a);
			cw_lo  = (VW'(q_data[3:0]) << q_rbits) | VW'(q_rem_b);
			word_d = (cw_hi << cw_len) | cw_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q  <= word_d;
			hbyte_q <= ccbe_pkg::ASCII_ZERO + {5'd0, q_ctrl.pad};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hdr_q  <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			hdr_q  <= q_ctrl.hdr;
			idx_q  <= q_last_idx;
		end else if (pop && busy_q) begin
			if (hdr_q) begin
				hdr_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - IDXW'(1);
			end
		end
	end

	assign empty     = !busy_q;
	assign is_header = hdr_q;
	assign last      = !hdr_q && (idx_q == '0);
	assign out_byte  = hdr_q ? hbyte_q : word_q[{idx_q, 3'b000} +: 8];

endmodule

`default_nettype wire

// ----- design/crc_codeword_byte_encoder_unit.sv -----
// CRC codeword byte encoder: top level with configuration registers.
//
// Input channel: present data_byte with push; the byte is taken at a clock
// edge where push is high and full is low. Each byte gives one codeword
// (whole-byte mode) or two joined nibble codewords, zero-padded in front to
// a byte boundary, sent MSB first as 2 to 5 bytes; two at the default
// length. The first item after reset is preceded by one header byte, the
// ASCII digit of its pad count (is_header high). last marks each item's
// final byte.
// Result channel: while empty is low the oldest byte is on out_byte; it is
// taken at an edge where pop is high. One byte leaves per cycle while pop
// stays high, also from one item's last byte to the next item's first.
// An item taken while idle is queued and then loaded into the serializer
// before its first byte is on out_byte. A two-entry queue between the
// remainder front end and the byte serializer keeps push open while results
// wait; when pop stays low the queue fills and full holds off the sender.
// Reset clears the queue and the serializer and rearms the header.
// Configuration: cfg_we writes register cfg_idx (0 generator bits, 1 generator
// length, 2 mode); the user, not the block, must use it only while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module crc_codeword_byte_encoder_unit #(
	parameter int MAX_GEN_LEN = ccbe_pkg::DEF_MAX_GEN_LEN
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [7:0]                        data_byte,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [7:0]                             out_byte,
	output logic                                   is_header,
	output logic                                   last,
	input  wire logic                              cfg_we,
	input  wire logic [ccbe_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [ccbe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int R    = MAX_GEN_LEN - 1;
	localparam int RBW  = $clog2(MAX_GEN_LEN);
	localparam int NB   = ((2 * (MAX_GEN_LEN + 3)) + 7) / ccbe_pkg::BYTE_BITS;
	localparam int IDXW = $clog2(NB);
	localparam int CW   = $bits(ccbe_pkg::ent_ctrl_t);
	localparam int FW   = CW + RBW + IDXW + 8 + 2 * R;

	logic [ccbe_pkg::CFG_GEN_W-1:0] gen_bits_q;
	logic [ccbe_pkg::GEN_LEN_W-1:0] gen_len_q;
	logic                           mode_q;

	logic                accept;
	ccbe_pkg::ent_ctrl_t f_ctrl, q_ctrl;
	logic [RBW-1:0]      f_rbits, q_rbits;
	logic [IDXW-1:0]     f_last_idx, q_last_idx;
	logic [R-1:0]        f_rem_a, f_rem_b, q_rem_a, q_rem_b;
	logic [7:0]          q_data;
	logic [FW-1:0]       q_wr_data, q_rd_data;
	logic                q_pop, q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_bits_q <= ccbe_pkg::RST_GEN_BITS;
			gen_len_q  <= ccbe_pkg::RST_GEN_LEN;
			mode_q     <= ccbe_pkg::RST_MODE;
		end else if (cfg_we) begin
			case (cfg_idx)
				ccbe_pkg::CFG_IDX_GEN_BITS: gen_bits_q <= cfg_wdata;
				ccbe_pkg::CFG_IDX_GEN_LEN:  gen_len_q  <= cfg_wdata[ccbe_pkg::GEN_LEN_W-1:0];
				ccbe_pkg::CFG_IDX_MODE:     mode_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	ccbe_front #(
		.MAX_GEN_LEN(MAX_GEN_LEN)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.generator_bits(gen_bits_q),
		.gen_len       (gen_len_q),
		.dataword_mode (mode_q),
		.ctrl          (f_ctrl),
		.rbits         (f_rbits),
		.last_idx      (f_last_idx),
		.rem_a         (f_rem_a),
		.rem_b         (f_rem_b)
	);

	assign q_wr_data = {f_ctrl, f_rbits, f_last_idx, data_byte, f_rem_a, f_rem_b};

	ccbe_fifo #(
		.WIDTH(FW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (q_wr_data),
		.rd_en    (q_pop),
		.rd_data  (q_rd_data),
		.full     (full),
		.not_empty(q_not_empty)
	);

	assign {q_ctrl, q_rbits, q_last_idx, q_data, q_rem_a, q_rem_b} = q_rd_data;

	ccbe_back #(
		.MAX_GEN_LEN(MAX_GEN_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_ctrl     (q_ctrl),
		.q_rbits    (q_rbits),
		.q_last_idx (q_last_idx),
		.q_data     (q_data),
		.q_rem_a    (q_rem_a),
		.q_rem_b    (q_rem_b),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.is_header  (is_header),
		.last       (last)
	);

	// header byte is never an item's final byte
	`ASSERT_NEVER(a_hdr_not_last, clk, arst_n, !empty && is_header && last, "header marked last")
	// header digit is always '0' to '7'
	`ASSERT_PROP(a_hdr_digit, clk, arst_n, (!empty && is_header) |-> (out_byte[7:3] == 5'b00110), "bad header digit")
	// codeword bytes of the same item follow a header transfer
	`ASSERT_PROP(a_hdr_followed, clk, arst_n, (!empty && is_header && pop) |=> (!empty && !is_header), "no codeword after header")
	// an item taken while idle reaches the result side through the queue and the serializer register
	`ASSERT_PROP(a_idle_latency, clk, arst_n, (push && !full && empty) |-> ##2 !empty, "item lost in queue")

endmodule

`default_nettype wire
